// ===== sv/tte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, character codes and colour tables for the text terminal
// engine with its ANSI CSI subset.
// ----------------------------------------------------------------------------
package tte_pkg;

  // field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ARG_W  = 8;

  // default geometry
  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  // attribute values
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_ESC      = 8'd27;
  localparam logic [CHAR_W-1:0] CHAR_LBRACKET = 8'd91;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BACKSP   = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_H  = 8'd72;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_M  = 8'd109;
  localparam logic [CHAR_W-1:0] CHAR_SEMI     = 8'd59;
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'd57;

  // result kinds
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_CURSOR = 2'd2
  } kind_e;

  // one result transaction
  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  cell_index;
    logic [CHAR_W-1:0] glyph;
    logic [ATTR_W-1:0] attribute;
    logic              last;
  } result_t;

  // all results caused by one character
  typedef struct packed {
    logic [1:0]    count;
    result_t [2:0] res;
  } step_t;

  // ansi normal palette mapped to vga colours
  function automatic logic [3:0] normal_colour(input logic [2:0] sel);
    logic [3:0] v;
    case (sel)
      3'd0:    v = 4'h0;
      3'd1:    v = 4'h4;
      3'd2:    v = 4'h2;
      3'd3:    v = 4'he;
      3'd4:    v = 4'h1;
      3'd5:    v = 4'h5;
      3'd6:    v = 4'h3;
      default: v = 4'hf;
    endcase
    return v;
  endfunction

  // ansi bright palette mapped to vga colours
  function automatic logic [3:0] bright_colour(input logic [2:0] sel);
    logic [3:0] v;
    case (sel)
      3'd0:    v = 4'h7;
      3'd1:    v = 4'hc;
      3'd2:    v = 4'ha;
      3'd3:    v = 4'he;
      3'd4:    v = 4'h9;
      3'd5:    v = 4'hd;
      3'd6:    v = 4'hb;
      default: v = 4'hf;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/tte_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_core
// Cursor, attribute and CSI parser state, with the single-pass step logic
// that turns one character into up to three results.
// ----------------------------------------------------------------------------
module tte_core #(
  parameter int COLUMNS = tte_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tte_pkg::DEFAULT_ROWS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tte_pkg::CHAR_W-1:0]  char_i,
  input  logic                        commit_i,
  input  logic                        cfg_we_i,
  input  logic [tte_pkg::ATTR_W-1:0]  cfg_wdata_i,
  output tte_pkg::step_t              step_o
);
  import tte_pkg::*;

  localparam logic [COL_W-1:0] COLUMNS_V = COL_W'(COLUMNS);
  localparam logic [ROW_W:0]   ROWS_V    = (ROW_W+1)'(ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);

  // row * columns + col, truncated to the index width
  function automatic logic [IDX_W-1:0] cell_at(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c);
    logic [ROW_W+COL_W-1:0] p;
    p = {{COL_W{1'b0}}, r} * {{ROW_W{1'b0}}, COLUMNS_V} + {{ROW_W{1'b0}}, c};
    return p[IDX_W-1:0];
  endfunction

  // decimal accumulate with saturation at 255
  function automatic logic [ARG_W-1:0] accumulate(input logic [ARG_W-1:0] a,
                                                  input logic [3:0] d);
    logic [ARG_W+3:0] v;
    v = {4'd0, a} * 12'd10 + {8'd0, d};
    return (v > 12'd255) ? 8'd255 : v[ARG_W-1:0];
  endfunction

  // state registers
  logic [ATTR_W-1:0] dflt_attr_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ATTR_W-1:0] attr_q, attr_d;
  logic              esc_q, esc_d;
  logic              seq_q, seq_d;
  logic [ARG_W-1:0]  arg1_q, arg1_d;
  logic              arg1_done_q, arg1_done_d;
  logic              sep_q, sep_d;
  logic [ARG_W-1:0]  arg2_q, arg2_d;
  logic              arg2_done_q, arg2_done_d;

  // step logic
  always_comb begin
    logic [ROW_W:0]   row_w;
    logic [COL_W:0]   col_w;
    logic [COL_W-1:0] col_n;
    logic             tail;
    logic             wrote;
    logic             scroll;
    logic             is_digit;
    logic [3:0]       digit;
    logic [ARG_W-1:0] n;
    logic [2:0]       sel;
    logic [3:0]       bg_n;
    logic [3:0]       bg_b;
    logic             move_ok;
    result_t          cur;

    row_w       = {1'b0, row_q};
    col_w       = '0;
    col_n       = col_q;
    tail        = 1'b0;
    wrote       = 1'b0;
    scroll      = 1'b0;
    is_digit    = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
    digit       = 4'(char_i - CHAR_ZERO);
    n           = arg1_q;
    sel         = 3'(arg1_q - 8'd30);
    bg_n        = normal_colour(3'(arg1_q - 8'd40));
    bg_b        = bright_colour(3'(arg1_q - 8'd100));
    move_ok     = sep_q && ({1'b0, arg1_q} < {3'd0, ROWS_V})
                  && ({1'b0, arg2_q} < {2'd0, COLUMNS_V});
    cur         = '0;

    attr_d      = attr_q;
    esc_d       = esc_q;
    seq_d       = seq_q;
    arg1_d      = arg1_q;
    arg1_done_d = arg1_done_q;
    sep_d       = sep_q;
    arg2_d      = arg2_q;
    arg2_done_d = arg2_done_q;
    step_o      = '0;

    if (char_i == CHAR_ESC) begin
      esc_d = 1'b1;
      tail  = 1'b1;
    end else if (char_i == CHAR_LBRACKET && esc_q) begin
      seq_d = 1'b1;
      tail  = 1'b1;
    end else if (char_i == CHAR_NEWLINE) begin
      row_w = {1'b0, row_q} + 1'b1;
      col_n = '0;
      tail  = 1'b1;
    end else if (char_i == CHAR_BACKSP) begin
      if (col_q != '0) begin
        col_n = col_q - 1'b1;
      end else if (row_q != '0) begin
        row_w = {1'b0, row_q} - 1'b1;
        col_n = COL_LAST;
      end
      tail = 1'b1;
    end else if (seq_q) begin
      // csi parameter and final bytes
      if (is_digit) begin
        if (!sep_q) begin
          if (!arg1_done_q) begin
            arg1_d = accumulate(arg1_q, digit);
          end
        end else if (!arg2_done_q) begin
          arg2_d = accumulate(arg2_q, digit);
        end
      end else if (char_i == CHAR_UPPER_H || char_i == CHAR_LOWER_M) begin
        esc_d       = 1'b0;
        seq_d       = 1'b0;
        arg1_d      = '0;
        arg2_d      = '0;
        arg1_done_d = 1'b0;
        sep_d       = 1'b0;
        arg2_done_d = 1'b0;
        if (char_i == CHAR_UPPER_H) begin
          if (move_ok) begin
            row_w = {1'b0, arg1_q[ROW_W-1:0]};
            col_n = arg2_q[COL_W-1:0];
            cur.kind       = KIND_CURSOR;
            cur.cell_index = cell_at(arg1_q[ROW_W-1:0], arg2_q[COL_W-1:0]);
            cur.last       = 1'b1;
            step_o.res[0]  = cur;
            step_o.count   = 2'd1;
          end
        end else begin
          // select graphic rendition
          if (n == 8'd0) begin
            attr_d = dflt_attr_q;
          end else if (n >= 8'd30 && n <= 8'd37) begin
            attr_d = {attr_q[7:4], normal_colour(sel)};
          end else if (n >= 8'd90 && n <= 8'd97) begin
            attr_d = {attr_q[7:4], bright_colour(3'(n - 8'd90))};
          end else if (n >= 8'd40 && n <= 8'd47) begin
            attr_d = {1'b0, bg_n[2:0], attr_q[3:0]};
          end else if (n >= 8'd100 && n <= 8'd107) begin
            attr_d = {1'b0, bg_b[2:0], attr_q[3:0]};
          end
        end
      end else if (char_i == CHAR_SEMI) begin
        if (!sep_q) begin
          sep_d       = 1'b1;
          arg1_done_d = 1'b1;
        end else begin
          arg2_done_d = 1'b1;
        end
      end else if (!sep_q) begin
        arg1_done_d = 1'b1;
      end else begin
        arg2_done_d = 1'b1;
      end
    end else begin
      // printable byte: cell write then advance with wrap
      wrote          = 1'b1;
      cur.kind       = KIND_WRITE;
      cur.cell_index = cell_at(row_q, col_q);
      cur.glyph      = char_i;
      cur.attribute  = attr_q;
      step_o.res[0]  = cur;
      col_w          = {1'b0, col_q} + 1'b1;
      if (col_w >= {1'b0, COLUMNS_V}) begin
        row_w = {1'b0, row_q} + 1'b1;
        col_n = '0;
      end else begin
        col_n = col_w[COL_W-1:0];
      end
      tail = 1'b1;
    end

    // scroll at the bottom, then the hardware cursor update
    if (tail) begin
      scroll = (row_w >= ROWS_V);
      if (scroll) begin
        row_w = {1'b0, ROW_LAST};
        cur           = '0;
        cur.kind      = KIND_SCROLL;
        cur.attribute = attr_q;
        if (wrote) begin
          step_o.res[1] = cur;
        end else begin
          step_o.res[0] = cur;
        end
      end
      cur            = '0;
      cur.kind       = KIND_CURSOR;
      cur.cell_index = cell_at(row_w[ROW_W-1:0], col_n);
      cur.last       = 1'b1;
      case ({wrote, scroll})
        2'b00:   step_o.res[0] = cur;
        2'b11:   step_o.res[2] = cur;
        default: step_o.res[1] = cur;
      endcase
      step_o.count = 2'd1 + {1'b0, wrote} + {1'b0, scroll};
    end

    row_d = row_w[ROW_W-1:0];
    col_d = col_n;
  end

  // state update on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= ATTR_RESET;
      esc_q       <= 1'b0;
      seq_q       <= 1'b0;
      arg1_q      <= '0;
      arg1_done_q <= 1'b0;
      sep_q       <= 1'b0;
      arg2_q      <= '0;
      arg2_done_q <= 1'b0;
    end else if (commit_i) begin
      col_q       <= col_d;
      row_q       <= row_d;
      attr_q      <= attr_d;
      esc_q       <= esc_d;
      seq_q       <= seq_d;
      arg1_q      <= arg1_d;
      arg1_done_q <= arg1_done_d;
      sep_q       <= sep_d;
      arg2_q      <= arg2_d;
      arg2_done_q <= arg2_done_d;
    end
  end

  // default attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      dflt_attr_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== sv/text_terminal_ansi_csi_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_ansi_csi_engine_core
// Character stream in, screen commands out: cell writes, scroll-up and
// hardware cursor updates, with an ANSI CSI subset (cursor position, colour).
//
//   channel   dir   payload                                   last
//   s_axis    in    tdata[7:0] char_code                      -
//   m_axis    out   tuser kind, tdata index/glyph/attribute   tlast on final
//   cfg       in    default attribute, write only             -
//
// A character sits in the input register, then the combinational step logic
// loads its zero to three results into the result bank.
// The result bank drains one transaction per cycle unless the receiver stalls;
// the next character steps as the bank's last result is taken.
// First result is valid after the input register and then the result bank.
// Reset loads ATTR_RESET, clears cursor, parser flags and both registers' valid.
// A stalled output holds the bank; the input register then fills and stalls.
// ----------------------------------------------------------------------------
module text_terminal_ansi_csi_engine_core #(
  parameter int COLUMNS = tte_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tte_pkg::DEFAULT_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [10:0] cell_index, [18:11] glyph,
                                        // [26:19] attribute, rest zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i       // default attribute
);
  import tte_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [CHAR_W-1:0] char_q;
  result_t [2:0]     bank_q;
  logic [1:0]        rem_q, rem_d;
  logic [1:0]        idx_q, idx_d;
  logic              in_hs;
  logic              out_hs;
  logic              fire;
  step_t             step;
  result_t           head;

  // handshakes
  assign in_hs  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_hs = m_axis_tvalid_o && m_axis_tready_i;
  assign fire   = in_valid_q && ((rem_q == 2'd0) || (rem_q == 2'd1 && out_hs));

  assign s_axis_tready_o = !in_valid_q || fire;

  // step logic and parser state
  tte_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_q),
    .commit_i    (fire),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_o      (step)
  );

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_hs) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      char_q <= s_axis_tdata_i;
    end
  end

  // result bank pointers
  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (out_hs) begin
      rem_d = rem_q - 1'b1;
      idx_d = idx_q + 1'b1;
    end
    if (fire && step.count != 2'd0) begin
      rem_d = step.count;
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && step.count != 2'd0) begin
      bank_q <= step.res;
    end
  end

  // output selection
  always_comb begin
    case (idx_q)
      2'd0:    head = bank_q[0];
      2'd1:    head = bank_q[1];
      2'd2:    head = bank_q[2];
      default: head = '0;
    endcase
  end

  assign m_axis_tvalid_o = (rem_q != 2'd0);
  assign m_axis_tdata_o  = {5'd0, head.attribute, head.glyph, head.cell_index};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last;

  // the final result of a character is exactly the last one left in the bank
  a_last_matches_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (rem_q == 2'd1)))
    else $error("tlast does not match the result count");

  // a scroll is always followed by the cursor update
  a_scroll_then_cursor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_hs && m_axis_tuser_o == KIND_SCROLL) |=>
      (m_axis_tvalid_o && m_axis_tuser_o == KIND_CURSOR))
    else $error("scroll not followed by cursor update");

  // a cell write never closes a character's results
  a_write_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_WRITE) |-> !m_axis_tlast_o)
    else $error("cell write marked last");

  // a held character keeps its byte until the step commits
  a_held_char_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> (in_valid_q && $stable(char_q)))
    else $error("held character lost");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text terminal engine. Character bytes go in on
// the slave stream. A behavioural copy of the cursor, attribute and CSI
// parser predicts every cell write, scroll and cursor update. Each master
// transaction is checked against the oldest prediction. A short directed
// pass is followed by random streams with mostly well-formed escape
// sequences, under three stall profiles.
// ----------------------------------------------------------------------------
module tb;
  import tte_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int TERM_COLS  = DEFAULT_COLUMNS;
  localparam int TERM_ROWS  = DEFAULT_ROWS;
  localparam int DRAIN_CYCLES = 16;

  // byte that ends a csi argument without meaning anything
  localparam logic [7:0] CHAR_FILLER = 8'd120;

  // palettes, entry 0 in the lowest nibble
  localparam logic [31:0] PAL_NORMAL = {4'hf, 4'h3, 4'h5, 4'h1, 4'he, 4'h2, 4'h4, 4'h0};
  localparam logic [31:0] PAL_BRIGHT = {4'hf, 4'hb, 4'hd, 4'h9, 4'he, 4'ha, 4'hc, 4'h7};

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_we_i        = 1'b0;
  logic [7:0]  cfg_wdata_i     = '0;

  // stall profile
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned chars_sent = 0;
  int unsigned mismatches = 0;

  // predicted screen commands, oldest first
  result_t pending_screen_cmds[$];

  // terminal state mirror
  logic [COL_W-1:0]  term_col;
  logic [ROW_W-1:0]  term_row;
  logic [ATTR_W-1:0] term_attr;
  logic [ATTR_W-1:0] term_default_attr;
  logic              esc_seen;
  logic              in_csi;
  logic [ARG_W-1:0]  arg_row;
  logic [ARG_W-1:0]  arg_col;
  logic              arg_row_done;
  logic              semi_seen;
  logic              arg_col_done;

  text_terminal_ansi_csi_engine_core #(
    .COLUMNS(TERM_COLS),
    .ROWS   (TERM_ROWS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void add_cmd(kind_e k, int idx, logic [7:0] g, logic [7:0] a, logic l);
    result_t r;
    r.kind       = k;
    r.cell_index = idx[IDX_W-1:0];
    r.glyph      = g;
    r.attribute  = a;
    r.last       = l;
    pending_screen_cmds.push_back(r);
  endfunction

  function automatic int cursor_cell();
    return int'(term_row) * TERM_COLS + int'(term_col);
  endfunction

  function automatic void reset_terminal();
    term_col          = '0;
    term_row          = '0;
    term_attr         = ATTR_RESET;
    term_default_attr = 8'd15;
    esc_seen          = 1'b0;
    in_csi            = 1'b0;
    arg_row           = '0;
    arg_col           = '0;
    arg_row_done      = 1'b0;
    semi_seen         = 1'b0;
    arg_col_done      = 1'b0;
  endfunction

  function automatic void end_csi();
    esc_seen     = 1'b0;
    in_csi       = 1'b0;
    arg_row      = '0;
    arg_col      = '0;
    arg_row_done = 1'b0;
    semi_seen    = 1'b0;
    arg_col_done = 1'b0;
  endfunction

  // decimal accumulate, clipped at 255
  function automatic logic [7:0] push_digit(logic [7:0] acc, logic [7:0] c);
    int v;
    v = int'(acc) * 10 + int'(c - CHAR_ZERO);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // sgr: colour select from the first argument
  function automatic void apply_sgr(logic [7:0] n);
    if (n == 0) begin
      term_attr = term_default_attr;
    end else if (n >= 30 && n <= 37) begin
      term_attr = {term_attr[7:4], PAL_NORMAL[(n - 30) * 4 +: 4]};
    end else if (n >= 90 && n <= 97) begin
      term_attr = {term_attr[7:4], PAL_BRIGHT[(n - 90) * 4 +: 4]};
    end else if (n >= 40 && n <= 47) begin
      term_attr = {1'b0, PAL_NORMAL[(n - 40) * 4 +: 3], term_attr[3:0]};
    end else if (n >= 100 && n <= 107) begin
      term_attr = {1'b0, PAL_BRIGHT[(n - 100) * 4 +: 3], term_attr[3:0]};
    end
  endfunction

  // one byte inside a csi sequence
  function automatic void apply_csi_byte(logic [7:0] c);
    logic [7:0] r;
    logic [7:0] k;
    logic       ok;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      if (!semi_seen) begin
        if (!arg_row_done) arg_row = push_digit(arg_row, c);
      end else if (!arg_col_done) begin
        arg_col = push_digit(arg_col, c);
      end
    end else if (c == CHAR_UPPER_H) begin
      ok = semi_seen && (arg_row < TERM_ROWS) && (arg_col < TERM_COLS);
      r  = arg_row;
      k  = arg_col;
      end_csi();
      if (ok) begin
        term_row = r[ROW_W-1:0];
        term_col = k[COL_W-1:0];
        add_cmd(KIND_CURSOR, cursor_cell(), 8'd0, 8'd0, 1'b1);
      end
    end else if (c == CHAR_LOWER_M) begin
      r = arg_row;
      end_csi();
      apply_sgr(r);
    end else if (c == CHAR_SEMI) begin
      if (!semi_seen) begin
        semi_seen    = 1'b1;
        arg_row_done = 1'b1;
      end else begin
        arg_col_done = 1'b1;
      end
    end else if (!semi_seen) begin
      arg_row_done = 1'b1;
    end else begin
      arg_col_done = 1'b1;
    end
  endfunction

  // whole effect of one accepted character on the screen
  function automatic void apply_char_to_screen(logic [7:0] c);
    if (c == CHAR_ESC) begin
      esc_seen = 1'b1;
    end else if (c == CHAR_LBRACKET && esc_seen) begin
      in_csi = 1'b1;
    end else if (c == CHAR_NEWLINE) begin
      term_row = term_row + 1'b1;
      term_col = '0;
    end else if (c == CHAR_BACKSP) begin
      if (term_col > 0) begin
        term_col = term_col - 1'b1;
      end else if (term_row > 0) begin
        term_row = term_row - 1'b1;
        term_col = COL_W'(TERM_COLS - 1);
      end
    end else if (in_csi) begin
      apply_csi_byte(c);
      return;
    end else begin
      add_cmd(KIND_WRITE, cursor_cell(), c, term_attr, 1'b0);
      term_col = term_col + 1'b1;
      if (term_col >= TERM_COLS) begin
        term_row = term_row + 1'b1;
        term_col = '0;
      end
    end
    if (term_row >= TERM_ROWS) begin
      add_cmd(KIND_SCROLL, 0, 8'd0, term_attr, 1'b0);
      term_row = ROW_W'(TERM_ROWS - 1);
    end
    add_cmd(KIND_CURSOR, cursor_cell(), 8'd0, 8'd0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // output checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : check_screen_cmds
    result_t exp_cmd;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_screen_cmds.size() == 0) begin
        $error("unexpected transaction: kind %0d index %0d", m_axis_tuser_o,
               m_axis_tdata_o[10:0]);
        mismatches++;
      end else begin
        exp_cmd = pending_screen_cmds.pop_front();
        check_field("kind", exp_cmd.kind, m_axis_tuser_o);
        check_field("cell_index", exp_cmd.cell_index, m_axis_tdata_o[10:0]);
        check_field("glyph", exp_cmd.glyph, m_axis_tdata_o[18:11]);
        check_field("attribute", exp_cmd.attribute, m_axis_tdata_o[26:19]);
        check_field("last", exp_cmd.last, m_axis_tlast_o);
        check_field("tdata padding", 0, m_axis_tdata_o[31:27]);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input transaction; valid stays up for a following byte
  task automatic send_char(input logic [7:0] c);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    apply_char_to_screen(c);
    chars_sent++;
  endtask

  task automatic send_number(input int n);
    string digits;
    digits = $sformatf("%0d", n);
    if ($urandom_range(7) == 0) send_char(CHAR_ZERO);
    for (int i = 0; i < digits.len(); i++) send_char(digits[i]);
  endtask

  // stop sending and let every predicted command drain
  task automatic wait_until_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_screen_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_default_attr(input logic [7:0] v);
    wait_until_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    term_default_attr = v;
  endtask

  function automatic int pick_arg(input int limit);
    int v;
    case ($urandom_range(3))
      0:       v = $urandom_range(limit - 3, limit - 1);
      3:       v = $urandom_range(limit, 300);
      default: v = $urandom_range(0, limit - 1);
    endcase
    return v;
  endfunction

  function automatic int pick_sgr();
    int v;
    case ($urandom_range(5))
      0:       v = 0;
      1:       v = 30 + $urandom_range(7);
      2:       v = 90 + $urandom_range(7);
      3:       v = 40 + $urandom_range(7);
      4:       v = 100 + $urandom_range(7);
      default: v = $urandom_range(300);
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_noise();
    logic [7:0] c;
    case ($urandom_range(7))
      0:       c = CHAR_ESC;
      1:       c = CHAR_LBRACKET;
      2:       c = CHAR_SEMI;
      3:       c = CHAR_ZERO + 8'($urandom_range(9));
      4:       c = CHAR_UPPER_H;
      5:       c = CHAR_LOWER_M;
      default: c = 8'($urandom_range(255));
    endcase
    return c;
  endfunction

  // cursor position sequence, sometimes missing parts
  task automatic send_cursor_move();
    send_char(CHAR_ESC);
    send_char(CHAR_LBRACKET);
    if ($urandom_range(7) != 0) send_number(pick_arg(TERM_ROWS));
    if ($urandom_range(9) == 0) send_char(CHAR_FILLER);
    if ($urandom_range(9) != 0) send_char(CHAR_SEMI);
    if ($urandom_range(7) != 0) send_number(pick_arg(TERM_COLS));
    if ($urandom_range(11) == 0) send_char(CHAR_SEMI);
    if ($urandom_range(11) == 0) send_number($urandom_range(99));
    send_char(CHAR_UPPER_H);
  endtask

  // colour sequence
  task automatic send_colour();
    send_char(CHAR_ESC);
    send_char(CHAR_LBRACKET);
    if ($urandom_range(7) != 0) send_number(pick_sgr());
    if ($urandom_range(7) == 0) begin
      send_char(CHAR_SEMI);
      send_number(pick_sgr());
    end
    send_char(CHAR_LOWER_M);
  endtask

  task automatic send_random_segment();
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(4) == 0) send_char(8'($urandom_range(255)));
          else send_char(8'($urandom_range(32, 126)));
        end
      end
      4, 5: send_cursor_move();
      6, 7: send_colour();
      8: begin
        repeat ($urandom_range(1, 8)) begin
          send_char($urandom_range(2) == 0 ? CHAR_BACKSP : CHAR_NEWLINE);
        end
      end
      default: begin
        repeat ($urandom_range(1, 8)) send_char(pick_noise());
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // write into the bottom-right cell, wrap and scroll, then newline scroll
  task automatic test_wrap_and_scroll();
    send_char(CHAR_ESC);
    send_char(CHAR_LBRACKET);
    send_char("2");
    send_char("4");
    send_char(CHAR_SEMI);
    send_char("7");
    send_char("9");
    send_char(CHAR_UPPER_H);
    send_char("X");
    send_char(CHAR_NEWLINE);
  endtask

  // backspace wrapping to the row above, then held at the top-left corner
  task automatic test_backspace();
    send_char(CHAR_BACKSP);
    send_char(CHAR_ESC);
    send_char(CHAR_LBRACKET);
    send_char(CHAR_SEMI);
    send_char(CHAR_UPPER_H);
    send_char(CHAR_BACKSP);
  endtask

  // bracket without escape prints, glyph extremes
  task automatic test_plain_glyphs();
    send_char(CHAR_LBRACKET);
    send_char(8'h00);
    send_char(8'hff);
  endtask

  // background colour, then restore of the default attribute
  task automatic test_colours();
    send_char(CHAR_ESC);
    send_char(CHAR_LBRACKET);
    send_char("4");
    send_char("4");
    send_char(CHAR_LOWER_M);
    send_char("a");
    send_char(CHAR_ESC);
    send_char(CHAR_LBRACKET);
    send_char(CHAR_LOWER_M);
    send_char("b");
  endtask

  task automatic test_random_stream(input int n_chars, input int send_pct, input int recv_pct);
    int unsigned target;
    target        = chars_sent + n_chars;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (chars_sent < target) send_random_segment();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_terminal();
    send_idle_pct = 9;
    recv_idle_pct = 88;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_default_attr(8'h2a);
    test_wrap_and_scroll();
    test_backspace();
    test_plain_glyphs();
    test_colours();

    set_default_attr(8'h00);
    test_random_stream(117, 9, 88);
    set_default_attr(8'hff);
    test_random_stream(117, 88, 9);
    set_default_attr(8'($urandom_range(255)));
    test_random_stream(117, 0, 0);

    wait_until_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * 400_000);
    $display("FAIL");
    $finish;
  end

endmodule
